// ----- rtl/tfn_pkg.sv -----
// ----------------------------------------------------------------------------
// tfn_pkg
// Widths and pipeline word types shared by the face normal datapath.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned FRAC_W  = 14;
  localparam int unsigned OUT_W   = FRAC_W + 2;
  localparam int unsigned EDGE_W  = COORD_W + 1;
  localparam int unsigned PROD_W  = 2 * EDGE_W;
  localparam int unsigned CROSS_W = PROD_W + 1;
  localparam int unsigned MAG_W   = PROD_W;
  localparam int unsigned SQ_W    = 2 * MAG_W;
  localparam int unsigned SUM_W   = SQ_W + 2;
  localparam int unsigned WIDE_W  = SUM_W + 2 * FRAC_W + 5;
  localparam int unsigned K_W     = FRAC_W + 1;
  localparam int unsigned NSTG    = FRAC_W + 1;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
  } tfn_cross_t;

  typedef struct packed {
    logic [2:0][WIDE_W-1:0] t;
    logic [2:0][WIDE_W-1:0] w;
    logic [2:0][K_W-1:0]    k;
    logic [2:0]             neg;
    logic [2:0]             kill;
    logic [WIDE_W-1:0]      a;
    logic [WIDE_W-1:0]      b;
    logic [K_W-1:0]         m;
    logic                   deg;
  } tfn_norm_t;

endpackage

// ----- rtl/tfn_cross.sv -----
// ----------------------------------------------------------------------------
// tfn_cross
// Edge vectors, partial products and exact cross product in three stages.
// ----------------------------------------------------------------------------
module tfn_cross (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [8:0][tfn_pkg::COORD_W-1:0]  vtx_i,
  output logic                              valid_o,
  output tfn_pkg::tfn_cross_t               cross_o
);
  import tfn_pkg::*;

  logic [2:0]                      vld_q;
  logic signed [EDGE_W-1:0]        ea_q [3];
  logic signed [EDGE_W-1:0]        eb_q [3];
  logic signed [PROD_W-1:0]        p_q  [3];
  logic signed [PROD_W-1:0]        q_q  [3];
  logic signed [CROSS_W-1:0]       c_d  [3];
  tfn_cross_t                      cross_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_d[i] = CROSS_W'(p_q[i]) - CROSS_W'(q_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      ea_q[i] <= EDGE_W'($signed(vtx_i[3+i])) - EDGE_W'($signed(vtx_i[i]));
      eb_q[i] <= EDGE_W'($signed(vtx_i[6+i])) - EDGE_W'($signed(vtx_i[i]));
    end
    p_q[0] <= ea_q[1] * eb_q[2];
    q_q[0] <= ea_q[2] * eb_q[1];
    p_q[1] <= ea_q[2] * eb_q[0];
    q_q[1] <= ea_q[0] * eb_q[2];
    p_q[2] <= ea_q[0] * eb_q[1];
    q_q[2] <= ea_q[1] * eb_q[0];
    for (int i = 0; i < 3; i++) begin
      cross_q.neg[i] <= c_d[i][CROSS_W-1];
      cross_q.mag[i] <= c_d[i][CROSS_W-1] ? MAG_W'(-c_d[i]) : MAG_W'(c_d[i]);
    end
  end

  assign valid_o = vld_q[2];
  assign cross_o = cross_q;

endmodule

// ----- rtl/tfn_prep.sv -----
// ----------------------------------------------------------------------------
// tfn_prep
// Squares, squared length and start values of the rounding search.
// ----------------------------------------------------------------------------
module tfn_prep (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  tfn_pkg::tfn_cross_t  cross_i,
  output logic                 valid_o,
  output tfn_pkg::tfn_norm_t   norm_o
);
  import tfn_pkg::*;

  logic [2:0]              vld_q;
  logic [2:0][SQ_W-1:0]    sq_q;
  logic [2:0]              neg_q;
  logic [2:0][SQ_W-1:0]    sq2_q;
  logic [2:0]              neg2_q;
  logic [SUM_W-1:0]        s_q;
  logic [WIDE_W-1:0]       s_w;
  logic [2:0][WIDE_W-1:0]  r_w;
  tfn_norm_t               norm_d;
  tfn_norm_t               norm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_comb begin
    s_w          = WIDE_W'(s_q);
    norm_d       = '0;
    norm_d.a     = s_w << (2 * FRAC_W + 2);
    norm_d.b     = s_w << (FRAC_W + 2);
    norm_d.m     = K_W'(1) << FRAC_W;
    norm_d.deg   = (s_q == '0);
    norm_d.neg   = neg2_q;
    for (int i = 0; i < 3; i++) begin
      r_w[i]         = WIDE_W'(sq2_q[i]) << (2 * FRAC_W + 2);
      // below the first odd square no candidate fits: keep k at zero
      norm_d.kill[i] = (r_w[i] < s_w);
      norm_d.t[i]    = r_w[i] - s_w;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= SQ_W'(cross_i.mag[i]) * SQ_W'(cross_i.mag[i]);
    end
    neg_q  <= cross_i.neg;
    sq2_q  <= sq_q;
    neg2_q <= neg_q;
    s_q    <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
    norm_q <= norm_d;
  end

  assign valid_o = vld_q[2];
  assign norm_o  = norm_q;

endmodule

// ----- rtl/tfn_norm_stage.sv -----
// ----------------------------------------------------------------------------
// tfn_norm_stage
// One bit of the rounded scale search for all three components.
// ----------------------------------------------------------------------------
module tfn_norm_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  tfn_pkg::tfn_norm_t  norm_i,
  output logic                valid_o,
  output tfn_pkg::tfn_norm_t  norm_o
);
  import tfn_pkg::*;

  logic                valid_q;
  tfn_norm_t           norm_d;
  tfn_norm_t           norm_q;
  logic [WIDE_W:0]     delta [3];
  logic [2:0]          take;
  logic [WIDE_W-1:0]   w_upd;

  always_comb begin
    norm_d      = norm_i;
    norm_d.a    = norm_i.a >> 2;
    norm_d.b    = norm_i.b >> 1;
    norm_d.m    = norm_i.m >> 1;
    for (int i = 0; i < 3; i++) begin
      // cost of setting this bit: (2k'-1)^2 s - (2k-1)^2 s
      delta[i] = (WIDE_W+1)'(norm_i.w[i]) + (WIDE_W+1)'(norm_i.a)
               - (WIDE_W+1)'(norm_i.b);
      take[i]  = !norm_i.kill[i] && ({1'b0, norm_i.t[i]} >= delta[i]);
      w_upd    = take[i] ? norm_i.w[i] + (norm_i.a << 1) : norm_i.w[i];
      norm_d.w[i] = w_upd >> 1;
      norm_d.t[i] = take[i] ? norm_i.t[i] - delta[i][WIDE_W-1:0] : norm_i.t[i];
      norm_d.k[i] = take[i] ? (norm_i.k[i] | norm_i.m) : norm_i.k[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    norm_q <= norm_d;
  end

  assign valid_o = valid_q;
  assign norm_o  = norm_q;

endmodule

// ----- rtl/triangle_face_normal.sv -----
// Throughput: one triangle per cycle; busy_o stays low, the pipeline never stalls.
// Depth is set by 3 cross product stages, 3 setup stages, one search stage per
// output bit (15) and the output register; the first stage loads at the accept edge.
// Reset clears all valid bits; no result is in flight after reset.
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle, Q8.8 vertices in, Q1.14 normal out.
// ----------------------------------------------------------------------------
module triangle_face_normal (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [tfn_pkg::COORD_W-1:0]  first_x_i,
  input  logic signed [tfn_pkg::COORD_W-1:0]  first_y_i,
  input  logic signed [tfn_pkg::COORD_W-1:0]  first_z_i,
  input  logic signed [tfn_pkg::COORD_W-1:0]  second_x_i,
  input  logic signed [tfn_pkg::COORD_W-1:0]  second_y_i,
  input  logic signed [tfn_pkg::COORD_W-1:0]  second_z_i,
  input  logic signed [tfn_pkg::COORD_W-1:0]  third_x_i,
  input  logic signed [tfn_pkg::COORD_W-1:0]  third_y_i,
  input  logic signed [tfn_pkg::COORD_W-1:0]  third_z_i,
  output logic                                done_o,
  output logic signed [tfn_pkg::OUT_W-1:0]    normal_x_o,
  output logic signed [tfn_pkg::OUT_W-1:0]    normal_y_o,
  output logic signed [tfn_pkg::OUT_W-1:0]    normal_z_o,
  output logic                                degenerate_o
);
  import tfn_pkg::*;

  logic [8:0][COORD_W-1:0]   vtx;
  logic                      cross_vld;
  tfn_cross_t                cross_w;
  logic [NSTG:0]             stg_vld;
  tfn_norm_t                 stg [NSTG+1];
  logic                      done_q;
  logic [2:0][OUT_W-1:0]     nrm_q;
  logic                      deg_q;
  logic [2:0][OUT_W-1:0]     nrm_d;

  assign busy_o = 1'b0;
  assign vtx = {third_z_i, third_y_i, third_x_i, second_z_i, second_y_i, second_x_i,
                first_z_i, first_y_i, first_x_i};

  tfn_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .vtx_i   (vtx),
    .valid_o (cross_vld),
    .cross_o (cross_w)
  );

  tfn_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cross_vld),
    .cross_i (cross_w),
    .valid_o (stg_vld[0]),
    .norm_o  (stg[0])
  );

  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    tfn_norm_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_vld[g]),
      .norm_i  (stg[g]),
      .valid_o (stg_vld[g+1]),
      .norm_o  (stg[g+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm_d[i] = OUT_W'(stg[NSTG].k[i]);
      if (stg[NSTG].neg[i]) begin
        nrm_d[i] = -nrm_d[i];
      end
      // drop the search result when the cross product vanished
      if (stg[NSTG].deg) begin
        nrm_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= stg_vld[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    nrm_q <= nrm_d;
    deg_q <= stg[NSTG].deg;
  end

  assign done_o       = done_q;
  assign normal_x_o   = nrm_q[0];
  assign normal_y_o   = nrm_q[1];
  assign normal_z_o   = nrm_q[2];
  assign degenerate_o = deg_q;

endmodule

// ----- dv/triangle_face_normal_tb.sv -----
// ----------------------------------------------------------------------------
// triangle_face_normal_tb
// Drives triangles into the face normal block with random gaps. Each result is
// checked field by field against a typed normal or an exact fixed-point normal
// computed here: a directed table of corner cases comes first, then random triangles.
// ----------------------------------------------------------------------------
module triangle_face_normal_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tfn_pkg::*;

  localparam int unsigned NUM_RANDOM = 1300;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [OUT_W-1:0]   comp_t;

  typedef struct {
    coord_t v [9];
  } tri_t;

  typedef struct {
    comp_t nx;
    comp_t ny;
    comp_t nz;
    logic  deg;
  } normal_t;

  typedef struct {
    tri_t    t;
    logic    typed;
    normal_t want;
  } row_t;

  logic   clk_i;
  logic   rst_ni;
  logic   start_i;
  logic   busy_o;
  coord_t first_x_i, first_y_i, first_z_i;
  coord_t second_x_i, second_y_i, second_z_i;
  coord_t third_x_i, third_y_i, third_z_i;
  logic   done_o;
  comp_t  normal_x_o, normal_y_o, normal_z_o;
  logic   degenerate_o;

  normal_t pending_normals [$];
  int unsigned errors;
  int unsigned cycles;

  triangle_face_normal u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .first_x_i, .first_y_i, .first_z_i,
    .second_x_i, .second_y_i, .second_z_i,
    .third_x_i, .third_y_i, .third_z_i,
    .done_o, .normal_x_o, .normal_y_o, .normal_z_o, .degenerate_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Largest k with (2k-1)^2 * s <= 4 * c^2 * 2^(2F): round to nearest, ties up.
  function automatic logic [K_W-1:0] unit_scale(logic [127:0] cmag, logic [127:0] s);
    logic [127:0] rhs;
    logic [127:0] odd;
    logic [K_W-1:0] k;
    logic [K_W-1:0] cand;
    rhs = (cmag * cmag) << (2 * FRAC_W + 2);
    k = '0;
    for (int b = FRAC_W; b >= 0; b--) begin
      cand = k | (K_W'(1) << b);
      odd = 128'(2 * cand - 1);
      if (odd * odd * s <= rhs) k = cand;
    end
    return k;
  endfunction

  function automatic normal_t face_normal(tri_t t);
    logic signed [63:0] e1 [3];
    logic signed [63:0] e2 [3];
    logic signed [63:0] c [3];
    logic [127:0] m [3];
    logic [127:0] s;
    logic [K_W-1:0] k;
    comp_t n [3];
    normal_t r;
    for (int i = 0; i < 3; i++) begin
      e1[i] = 64'(t.v[3+i]) - 64'(t.v[i]);
      e2[i] = 64'(t.v[6+i]) - 64'(t.v[i]);
    end
    c[0] = e1[1] * e2[2] - e1[2] * e2[1];
    c[1] = e1[2] * e2[0] - e1[0] * e2[2];
    c[2] = e1[0] * e2[1] - e1[1] * e2[0];
    for (int i = 0; i < 3; i++) m[i] = 128'(c[i] < 0 ? -c[i] : c[i]);
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    r.deg = (s == 0);
    for (int i = 0; i < 3; i++) begin
      k = r.deg ? '0 : unit_scale(m[i], s);
      n[i] = c[i] < 0 ? -comp_t'(k) : comp_t'(k);
    end
    r.nx = n[0];
    r.ny = n[1];
    r.nz = n[2];
    return r;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0:       return coord_t'($urandom_range(1) ? 16'h7fff : 16'h8000);
      1, 2:    return coord_t'($signed($urandom_range(16)) - 8);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    int signed a;
    int signed b;
    for (int i = 0; i < 9; i++) t.v[i] = rand_coord();
    // collinear or coincident vertices: third = first + a times the edge b
    if ($urandom_range(9) == 0) begin
      a = $signed($urandom_range(4)) - 2;
      for (int i = 0; i < 3; i++) begin
        t.v[3+i] = coord_t'($signed($urandom_range(200)) - 100);
        t.v[i]   = coord_t'($signed($urandom_range(200)) - 100);
        b = t.v[3+i] - t.v[i];
        t.v[6+i] = coord_t'(t.v[i] + a * b);
      end
    end
    return t;
  endfunction

  function automatic tri_t mk(int signed a [9]);
    tri_t t;
    for (int i = 0; i < 9; i++) t.v[i] = coord_t'(a[i]);
    return t;
  endfunction

  task automatic send_triangle(tri_t t, int unsigned gap);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    first_x_i  <= t.v[0];
    first_y_i  <= t.v[1];
    first_z_i  <= t.v[2];
    second_x_i <= t.v[3];
    second_y_i <= t.v[4];
    second_z_i <= t.v[5];
    third_x_i  <= t.v[6];
    third_y_i  <= t.v[7];
    third_z_i  <= t.v[8];
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 95) return $urandom_range(3);
    return $urandom_range(40);
  endfunction

  // Check each done word against the oldest pending normal.
  always @(posedge clk_i) begin
    normal_t want;
    if (rst_ni && done_o) begin
      if (pending_normals.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        want = pending_normals.pop_front();
        if (normal_x_o !== want.nx) begin
          $error("normal_x: expected %0d, got %0d", want.nx, normal_x_o);
          errors++;
        end
        if (normal_y_o !== want.ny) begin
          $error("normal_y: expected %0d, got %0d", want.ny, normal_y_o);
          errors++;
        end
        if (normal_z_o !== want.nz) begin
          $error("normal_z: expected %0d, got %0d", want.nz, normal_z_o);
          errors++;
        end
        if (degenerate_o !== want.deg) begin
          $error("degenerate: expected %0d, got %0d", want.deg, degenerate_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    row_t row;
    normal_t zero_deg;
    normal_t want;
    int unsigned drain;
    errors = 0;
    cycles = 0;
    zero_deg = '{nx: 0, ny: 0, nz: 0, deg: 1'b1};
    rst_ni = 1'b0;
    start_i = 1'b0;
    {first_x_i, first_y_i, first_z_i} = '0;
    {second_x_i, second_y_i, second_z_i} = '0;
    {third_x_i, third_y_i, third_z_i} = '0;

    // typed rows: degenerate cases and axis-aligned unit normals
    rows.push_back('{mk('{0, 0, 0, 0, 0, 0, 0, 0, 0}), 1'b1, zero_deg});
    rows.push_back('{mk('{-32768, -32768, -32768, -32768, -32768, -32768,
                          -32768, -32768, -32768}), 1'b1, zero_deg});
    rows.push_back('{mk('{32767, 32767, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767}), 1'b1, zero_deg});
    rows.push_back('{mk('{0, 0, 0, 256, 256, 256, 512, 512, 512}), 1'b1, zero_deg});
    rows.push_back('{mk('{-32768, 0, 0, 32767, 0, 0, 0, 0, 0}), 1'b1, zero_deg});
    rows.push_back('{mk('{0, 0, 0, 256, 0, 0, 0, 256, 0}), 1'b1,
                     '{nx: 0, ny: 0, nz: 16384, deg: 1'b0}});
    rows.push_back('{mk('{0, 0, 0, 0, 256, 0, 256, 0, 0}), 1'b1,
                     '{nx: 0, ny: 0, nz: -16384, deg: 1'b0}});
    rows.push_back('{mk('{0, 0, 0, 0, 1, 0, 0, 0, 1}), 1'b1,
                     '{nx: 16384, ny: 0, nz: 0, deg: 1'b0}});
    rows.push_back('{mk('{0, 0, 0, 0, 0, 1, 1, 0, 0}), 1'b1,
                     '{nx: 0, ny: 16384, nz: 0, deg: 1'b0}});
    // predicted rows: range extremes and near-diagonal normals
    rows.push_back('{mk('{-32768, -32768, -32768, 32767, -32768, -32768,
                          -32768, 32767, -32768}), 1'b0, zero_deg});
    rows.push_back('{mk('{32767, 32767, 32767, -32768, 32767, -32768,
                          32767, -32768, -32768}), 1'b0, zero_deg});
    rows.push_back('{mk('{-32768, 32767, -32768, 32767, -32768, 32767,
                          -32768, -32768, 32767}), 1'b0, zero_deg});
    rows.push_back('{mk('{32767, -32768, 0, -32768, 32767, 0,
                          0, 0, 32767}), 1'b0, zero_deg});
    rows.push_back('{mk('{0, 0, 0, 1, 0, 0, 0, 1, 1}), 1'b0, zero_deg});
    rows.push_back('{mk('{0, 0, 0, 1, 1, 0, 0, 1, 1}), 1'b0, zero_deg});
    rows.push_back('{mk('{0, 0, 0, 3, 0, 0, 0, 4, 0}), 1'b0, zero_deg});
    rows.push_back('{mk('{5, -7, 9, -1, 2, -3, 4, 6, -8}), 1'b0, zero_deg});
    rows.push_back('{mk('{-1, -1, -1, 0, 0, 0, 1, 0, -1}), 1'b0, zero_deg});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      row = rows[i];
      want = row.typed ? row.want : face_normal(row.t);
      send_triangle(row.t, i % 3);
      pending_normals.push_back(want);
    end

    for (int unsigned n = 0; n < NUM_RANDOM; n++) begin
      row.t = rand_tri();
      // hold long bursts back to back now and then
      send_triangle(row.t, (n % 200 < 40) ? 0 : pick_gap());
      pending_normals.push_back(face_normal(row.t));
    end
    start_i <= 1'b0;

    while (pending_normals.size() != 0) @(posedge clk_i);
    drain = 30;
    repeat (drain) @(posedge clk_i);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
